// ===== sv/bfa_pkg.sv =====
package bfa_pkg;

  localparam int MAX_JOBS_DEF  = 16;
  localparam int ADDR_BITS_DEF = 20;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 16;
  localparam int SIZE_W  = 21;
  localparam int TIME_W  = 32;
  localparam int ST_W    = 3;
  localparam int OBASE_W = 20;
  localparam int TOT_W   = 21;

  localparam logic [TOT_W-1:0] TOTAL_RESET = 21'h100000;

  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 3'd0;
  localparam logic [ST_W-1:0] ST_EXISTS = 3'd1;
  localparam logic [ST_W-1:0] ST_NOFIT  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOJOB  = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE   = 3'd4;

  // what every cell of the slot chain does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_ROT,
    CM_PACK,
    CM_INS
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } cell_ctl_t;

endpackage

// ===== sv/bfa_if.sv =====
interface bfa_in_if;
  import bfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   job_id;
  logic [SIZE_W-1:0] job_size;
  logic [TIME_W-1:0] job_time;
  logic [TIME_W-1:0] ticks;
  modport source (output valid, command, job_id, job_size, job_time, ticks, input ready);
  modport sink   (input valid, command, job_id, job_size, job_time, ticks, output ready);
endinterface

interface bfa_out_if;
  import bfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [ID_W-1:0]    result_id;
  logic [OBASE_W-1:0] base_address;
  logic               last;
  modport source (output valid, status, result_id, base_address, last, input ready);
  modport sink   (input valid, status, result_id, base_address, last, output ready);
endinterface

interface bfa_cfg_if;
  import bfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/best_fit_job_memory_allocator.sv =====
// Channel  Role   Transaction
// in_ch    sink   command, job_id, job_size, job_time, ticks
// out_ch   source status, result_id, base_address, last
// cfg_ch   sink   total_memory write, always ready
//
// Jobs live in a chain of MAX_JOBS slot cells kept sorted by base and packed to cell 0.
// Every scan rotates the whole chain once past cell 0, one slot a cycle.
// After the scan, add inserts and responds (refused: only responds); remove packs and
// responds (id missing: only responds); advance emits and packs (none expire: only responds).
// A stalled output holds the expiry pass at the expiring slot; input waits until idle.
// Synchronous active-low reset empties every slot and sets the memory size to 2^20.
module best_fit_job_memory_allocator import bfa_pkg::*; #(
  parameter int MAX_JOBS  = MAX_JOBS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bfa_in_if.sink    in_ch,
  bfa_out_if.source out_ch,
  bfa_cfg_if.sink   cfg_ch
);

  localparam int SW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int GW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;
  localparam logic [SW-1:0] LAST_STEP = SW'(MAX_JOBS - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_FIN  = 7'b0000100,
    S_INS  = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_PACK = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TOT_W-1:0]     total_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [ID_W-1:0]      id_r;
  logic [SIZE_W-1:0]    size_r;
  logic [TIME_W-1:0]    jtime_r;
  logic [TIME_W-1:0]    ticks_r;
  logic [SW-1:0]        step_r, step_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        emit_r, emit_nxt;
  logic                 hit_r, hit_nxt;
  logic                 found_r, found_nxt;
  logic [GW-1:0]        cur_r, cur_nxt;
  logic [GW-1:0]        blen_r, blen_nxt;
  logic [ADDR_BITS-1:0] best_r, best_nxt;
  logic [ADDR_BITS-1:0] rbase_r, rbase_nxt;
  logic [ST_W-1:0]      st_r, st_nxt;

  logic               ov_r, ov_nxt;
  logic [ST_W-1:0]    ost_r, ost_nxt;
  logic [ID_W-1:0]    oid_r, oid_nxt;
  logic [OBASE_W-1:0] obase_r, obase_nxt;
  logic               olast_r, olast_nxt;

  // chain wiring
  logic                 cv    [MAX_JOBS];
  logic [ID_W-1:0]      cid   [MAX_JOBS];
  logic [ADDR_BITS-1:0] cbase [MAX_JOBS];
  logic [SIZE_W-1:0]    csize [MAX_JOBS];
  logic [TIME_W-1:0]    ctime [MAX_JOBS];
  logic                 caft  [MAX_JOBS];
  cell_ctl_t            ctl;

  // what re-enters the chain end while it rotates
  logic                 fv;
  logic [TIME_W-1:0]    ftime;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
      logic                 lv, la, rv;
      logic [ID_W-1:0]      lid, rid;
      logic [ADDR_BITS-1:0] lbase, rbase;
      logic [SIZE_W-1:0]    lsize, rsize;
      logic [TIME_W-1:0]    ltime, rtime;
      if (gi == 0) begin : g_first
        assign lv    = 1'b1;
        assign la    = 1'b0;
        assign lid   = '0;
        assign lbase = '0;
        assign lsize = '0;
        assign ltime = '0;
      end else begin : g_mid
        assign lv    = cv[gi-1];
        assign la    = caft[gi-1];
        assign lid   = cid[gi-1];
        assign lbase = cbase[gi-1];
        assign lsize = csize[gi-1];
        assign ltime = ctime[gi-1];
      end
      if (gi == MAX_JOBS - 1) begin : g_end
        assign rv    = fv;
        assign rid   = cid[0];
        assign rbase = cbase[0];
        assign rsize = csize[0];
        assign rtime = ftime;
      end else begin : g_link
        assign rv    = cv[gi+1];
        assign rid   = cid[gi+1];
        assign rbase = cbase[gi+1];
        assign rsize = csize[gi+1];
        assign rtime = ctime[gi+1];
      end
      bfa_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_i        (ctl),
        .left_v_i     (lv),
        .left_after_i (la),
        .left_id_i    (lid),
        .left_base_i  (lbase),
        .left_size_i  (lsize),
        .left_time_i  (ltime),
        .right_v_i    (rv),
        .right_id_i   (rid),
        .right_base_i (rbase),
        .right_size_i (rsize),
        .right_time_i (rtime),
        .new_id_i     (id_r),
        .new_base_i   (best_r),
        .new_size_i   (size_r),
        .new_time_i   (jtime_r),
        .v_o          (cv[gi]),
        .id_o         (cid[gi]),
        .base_o       (cbase[gi]),
        .size_o       (csize[gi]),
        .time_o       (ctime[gi]),
        .after_o      (caft[gi])
      );
    end
  endgenerate

  // usable memory, capped at the address space
  logic [GW-1:0] tot_ext, cap, mem;
  assign tot_ext = GW'(total_r);
  assign cap     = GW'(1) << ADDR_BITS;
  assign mem     = (tot_ext > cap) ? cap : tot_ext;

  // head slot arithmetic
  logic [GW-1:0]     hbase, hend, gend, glen;
  logic              gap_ok;
  logic [TIME_W-1:0] tdec;
  logic              head_exp;

  assign hbase    = GW'(cbase[0]);
  assign hend     = hbase + GW'(csize[0]);
  assign gend     = (state_r == S_SCAN) ? ((hbase > mem) ? mem : hbase) : mem;
  assign glen     = gend - cur_r;
  assign gap_ok   = (gend > cur_r) && (glen >= GW'(size_r)) && (!found_r || (glen < blen_r));
  assign tdec     = (ctime[0] > ticks_r) ? (ctime[0] - ticks_r) : '0;
  assign head_exp = cv[0] && (ctime[0] == '0);

  logic out_free;
  assign out_free = !ov_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    emit_nxt  = emit_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    cur_nxt   = cur_r;
    blen_nxt  = blen_r;
    best_nxt  = best_r;
    rbase_nxt = rbase_r;
    st_nxt    = st_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ost_nxt   = ost_r;
    oid_nxt   = oid_r;
    obase_nxt = obase_r;
    olast_nxt = olast_r;
    ctl.mode  = CM_HOLD;
    fv        = cv[0];
    ftime     = ctime[0];

    unique case (state_r)
      S_IDLE: begin
        step_nxt  = '0;
        cnt_nxt   = '0;
        emit_nxt  = '0;
        hit_nxt   = 1'b0;
        found_nxt = 1'b0;
        cur_nxt   = '0;
        blen_nxt  = '0;
        best_nxt  = '0;
        if (in_ch.valid && (in_ch.command == CMD_ADD || in_ch.command == CMD_REMOVE ||
                            in_ch.command == CMD_ADVANCE)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.mode = CM_ROT;
        step_nxt = step_r + SW'(1);
        if (cv[0]) begin
          if (cmd_r == CMD_ADD) begin
            if (cid[0] == id_r) hit_nxt = 1'b1;
            if (gap_ok) begin
              found_nxt = 1'b1;
              blen_nxt  = glen;
              best_nxt  = ADDR_BITS'(cur_r);
            end
            if (hend > cur_r) cur_nxt = hend;
          end else if (cmd_r == CMD_REMOVE) begin
            if (cid[0] == id_r && !hit_r) begin
              hit_nxt   = 1'b1;
              rbase_nxt = cbase[0];
              fv        = 1'b0;
            end
          end else begin
            ftime = tdec;
            if (tdec == '0) cnt_nxt = cnt_r + CW'(1);
          end
        end
        if (step_r == LAST_STEP) state_nxt = S_FIN;
      end
      S_FIN: begin
        step_nxt = '0;
        if (cmd_r == CMD_ADD) begin
          // closing gap up to the end of memory
          if (gap_ok) begin
            found_nxt = 1'b1;
            best_nxt  = ADDR_BITS'(cur_r);
          end
          if (hit_r) begin
            st_nxt    = ST_EXISTS;
            state_nxt = S_RESP;
          end else if (!(gap_ok || found_r) || size_r == '0 || cv[MAX_JOBS-1]) begin
            st_nxt    = ST_NOFIT;
            state_nxt = S_RESP;
          end else begin
            st_nxt    = ST_OK;
            state_nxt = S_INS;
          end
        end else if (cmd_r == CMD_REMOVE) begin
          st_nxt    = hit_r ? ST_OK : ST_NOJOB;
          state_nxt = hit_r ? S_PACK : S_RESP;
        end else begin
          st_nxt    = (cnt_r == '0) ? ST_NONE : ST_OK;
          state_nxt = (cnt_r == '0) ? S_RESP : S_EMIT;
        end
      end
      S_INS: begin
        ctl.mode  = CM_INS;
        rbase_nxt = best_r;
        state_nxt = S_RESP;
      end
      S_EMIT: begin
        if (!head_exp || out_free) begin
          ctl.mode = CM_ROT;
          step_nxt = step_r + SW'(1);
          if (head_exp) begin
            fv        = 1'b0;
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            oid_nxt   = cid[0];
            obase_nxt = OBASE_W'(GW'(cbase[0]));
            olast_nxt = ((emit_r + CW'(1)) == cnt_r);
            emit_nxt  = emit_r + CW'(1);
          end
          if (step_r == LAST_STEP) begin
            step_nxt  = '0;
            state_nxt = S_PACK;
          end
        end
      end
      S_PACK: begin
        // close the holes left by freed jobs
        ctl.mode = CM_PACK;
        fv       = 1'b0;
        step_nxt = step_r + SW'(1);
        if (step_r == LAST_STEP) state_nxt = (cmd_r == CMD_ADVANCE) ? S_IDLE : S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          oid_nxt   = (st_r == ST_NONE) ? '0 : id_r;
          obase_nxt = (st_r == ST_OK) ? OBASE_W'(GW'(rbase_r)) : '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= TOTAL_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid) total_r <= cfg_ch.data;
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      cmd_r   <= in_ch.command;
      id_r    <= in_ch.job_id;
      size_r  <= in_ch.job_size;
      jtime_r <= in_ch.job_time;
      ticks_r <= in_ch.ticks;
    end
    step_r  <= step_nxt;
    cnt_r   <= cnt_nxt;
    emit_r  <= emit_nxt;
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
    cur_r   <= cur_nxt;
    blen_r  <= blen_nxt;
    best_r  <= best_nxt;
    rbase_r <= rbase_nxt;
    st_r    <= st_nxt;
    ost_r   <= ost_nxt;
    oid_r   <= oid_nxt;
    obase_r <= obase_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = ost_r;
  assign out_ch.result_id    = oid_r;
  assign out_ch.base_address = obase_r;
  assign out_ch.last         = olast_r;

endmodule

// ===== sv/bfa_cell.sv =====
module bfa_cell import bfa_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl_i,
  input  logic                 left_v_i,
  input  logic                 left_after_i,
  input  logic [ID_W-1:0]      left_id_i,
  input  logic [ADDR_BITS-1:0] left_base_i,
  input  logic [SIZE_W-1:0]    left_size_i,
  input  logic [TIME_W-1:0]    left_time_i,
  input  logic                 right_v_i,
  input  logic [ID_W-1:0]      right_id_i,
  input  logic [ADDR_BITS-1:0] right_base_i,
  input  logic [SIZE_W-1:0]    right_size_i,
  input  logic [TIME_W-1:0]    right_time_i,
  input  logic [ID_W-1:0]      new_id_i,
  input  logic [ADDR_BITS-1:0] new_base_i,
  input  logic [SIZE_W-1:0]    new_size_i,
  input  logic [TIME_W-1:0]    new_time_i,
  output logic                 v_o,
  output logic [ID_W-1:0]      id_o,
  output logic [ADDR_BITS-1:0] base_o,
  output logic [SIZE_W-1:0]    size_o,
  output logic [TIME_W-1:0]    time_o,
  output logic                 after_o
);

  logic                 v_r;
  logic [ID_W-1:0]      id_r;
  logic [ADDR_BITS-1:0] base_r;
  logic [SIZE_W-1:0]    size_r;
  logic [TIME_W-1:0]    time_r;

  // this slot lies at or beyond the insertion point
  assign after_o = !v_r || (base_r > new_base_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      case (ctl_i.mode)
        CM_ROT: begin
          v_r    <= right_v_i;
          id_r   <= right_id_i;
          base_r <= right_base_i;
          size_r <= right_size_i;
          time_r <= right_time_i;
        end
        CM_PACK: begin
          // pull a job down into an empty slot, give it away to an empty left neighbour
          if (!v_r && right_v_i) begin
            v_r    <= 1'b1;
            id_r   <= right_id_i;
            base_r <= right_base_i;
            size_r <= right_size_i;
            time_r <= right_time_i;
          end else if (v_r && !left_v_i) begin
            v_r <= 1'b0;
          end
        end
        CM_INS: begin
          if (after_o) begin
            if (left_after_i) begin
              v_r    <= left_v_i;
              id_r   <= left_id_i;
              base_r <= left_base_i;
              size_r <= left_size_i;
              time_r <= left_time_i;
            end else begin
              v_r    <= 1'b1;
              id_r   <= new_id_i;
              base_r <= new_base_i;
              size_r <= new_size_i;
              time_r <= new_time_i;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign v_o    = v_r;
  assign id_o   = id_r;
  assign base_o = base_r;
  assign size_o = size_r;
  assign time_o = time_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bfa_pkg::*;

  localparam int                JOBS       = MAX_JOBS_DEF;
  localparam longint unsigned   MEM_CAP    = 64'd1 << ADDR_BITS_DEF;
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  // longest tail after the final result: a full advance pass plus margin
  localparam int                SETTLE     = 3 * JOBS + 20;
  localparam int                PHASES     = 8;
  localparam int                PER_PHASE  = 44;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   job_id;
    logic [SIZE_W-1:0] job_size;
    logic [TIME_W-1:0] job_time;
    logic [TIME_W-1:0] ticks;
  } job_cmd_t;

  typedef struct {
    logic [ST_W-1:0]    status;
    logic [ID_W-1:0]    result_id;
    logic [OBASE_W-1:0] base_address;
    logic               last;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();
  bfa_cfg_if cfg_ch ();

  best_fit_job_memory_allocator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Commands waiting to be driven, and results the allocator still owes
  job_cmd_t      pending_cmds[$];
  alloc_result_t due_results[$];
  job_cmd_t      cur_cmd;

  int  errors    = 0;
  int  send_idle = 0;  // percentage of cycles the sender stays quiet
  int  recv_idle = 0;  // percentage of cycles the receiver stalls
  bit  hold_in   = 1'b0;

  // Shadow of the allocator: job table and memory size register
  logic [TOT_W-1:0]   mem_total;
  logic               job_valid [JOBS];
  logic [ID_W-1:0]    job_ident [JOBS];
  logic [OBASE_W:0]   job_base  [JOBS];
  logic [SIZE_W-1:0]  job_len   [JOBS];
  logic [TIME_W-1:0]  job_left  [JOBS];
  int                 by_base   [JOBS];

  // Order live slots by base, lower slot first on equal base
  function automatic int sort_jobs_by_base();
    int n;
    int j;
    n = 0;
    for (int i = 0; i < JOBS; i++) begin
      if (job_valid[i]) begin
        j = n;
        while (j > 0 && job_base[by_base[j-1]] > job_base[i]) begin
          by_base[j] = by_base[j-1];
          j--;
        end
        by_base[j] = i;
        n++;
      end
    end
    return n;
  endfunction

  function automatic int find_job(logic [ID_W-1:0] id);
    for (int i = 0; i < JOBS; i++)
      if (job_valid[i] && job_ident[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_result(logic [ST_W-1:0] st, logic [ID_W-1:0] id,
                                      longint unsigned base, logic last);
    alloc_result_t r;
    r.status       = st;
    r.result_id    = id;
    r.base_address = base[OBASE_W-1:0];
    r.last         = last;
    due_results.push_back(r);
  endfunction

  // Apply one accepted command to the shadow table and queue its results
  function automatic void allocate_and_predict(job_cmd_t c);
    int              s;
    int              n;
    int              cnt;
    int              r;
    int              free_slot;
    bit              found;
    longint unsigned mem;
    longint unsigned cur;
    longint unsigned gap_end;
    longint unsigned e;
    longint unsigned best_base;
    longint unsigned best_len;
    case (c.command)
      CMD_ADD: begin
        if (find_job(c.job_id) >= 0) begin
          push_result(ST_EXISTS, c.job_id, 0, 1'b1);
          return;
        end
        free_slot = -1;
        for (int i = JOBS - 1; i >= 0; i--)
          if (!job_valid[i]) free_slot = i;
        mem = (mem_total > MEM_CAP) ? MEM_CAP : longint'(mem_total);
        found = 1'b0;
        best_base = 0;
        best_len = 0;
        if (free_slot >= 0 && c.job_size != 0) begin
          n = sort_jobs_by_base();
          cur = 0;
          for (int k = 0; k <= n; k++) begin
            gap_end = (k < n) ? longint'(job_base[by_base[k]]) : mem;
            if (gap_end > mem) gap_end = mem;
            if (gap_end > cur && gap_end - cur >= c.job_size &&
                (!found || gap_end - cur < best_len)) begin
              found = 1'b1;
              best_len = gap_end - cur;
              best_base = cur;
            end
            if (k < n) begin
              e = longint'(job_base[by_base[k]]) + longint'(job_len[by_base[k]]);
              if (e > cur) cur = e;
            end
          end
        end
        if (!found) begin
          push_result(ST_NOFIT, c.job_id, 0, 1'b1);
          return;
        end
        job_valid[free_slot] = 1'b1;
        job_ident[free_slot] = c.job_id;
        job_base[free_slot]  = best_base[OBASE_W:0];
        job_len[free_slot]   = c.job_size;
        job_left[free_slot]  = c.job_time;
        push_result(ST_OK, c.job_id, best_base, 1'b1);
      end
      CMD_REMOVE: begin
        s = find_job(c.job_id);
        if (s < 0) begin
          push_result(ST_NOJOB, c.job_id, 0, 1'b1);
        end else begin
          job_valid[s] = 1'b0;
          push_result(ST_OK, c.job_id, job_base[s], 1'b1);
        end
      end
      CMD_ADVANCE: begin
        for (int i = 0; i < JOBS; i++)
          if (job_valid[i])
            job_left[i] = (job_left[i] > c.ticks) ? job_left[i] - c.ticks : '0;
        n = sort_jobs_by_base();
        cnt = 0;
        for (int k = 0; k < n; k++)
          if (job_left[by_base[k]] == 0) cnt++;
        if (cnt == 0) begin
          push_result(ST_NONE, '0, 0, 1'b1);
          return;
        end
        r = 0;
        for (int k = 0; k < n; k++) begin
          s = by_base[k];
          if (job_left[s] == 0) begin
            push_result(ST_OK, job_ident[s], job_base[s], r == cnt - 1);
            job_valid[s] = 1'b0;
            r++;
          end
        end
      end
      default: ;  // unused command: no effect, no result
    endcase
  endfunction

  // Driver: predict on each accepted transaction, then offer the next command
  always @(posedge clk) begin
    logic v;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      v = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        allocate_and_predict(cur_cmd);
        v = 1'b0;
      end
      if (!v && pending_cmds.size() > 0 && !hold_in &&
          $urandom_range(0, 99) >= send_idle) begin
        cur_cmd = pending_cmds.pop_front();
        in_ch.command  <= cur_cmd.command;
        in_ch.job_id   <= cur_cmd.job_id;
        in_ch.job_size <= cur_cmd.job_size;
        in_ch.job_time <= cur_cmd.job_time;
        in_ch.ticks    <= cur_cmd.ticks;
        v = 1'b1;
      end
      in_ch.valid <= v;
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t x;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d id %0d base %0d",
                 out_ch.status, out_ch.result_id, out_ch.base_address);
          errors++;
        end else begin
          x = due_results.pop_front();
          if (out_ch.status !== x.status) begin
            $error("status: expected %0d, got %0d", x.status, out_ch.status);
            errors++;
          end
          if (out_ch.result_id !== x.result_id) begin
            $error("result_id: expected %0d, got %0d", x.result_id, out_ch.result_id);
            errors++;
          end
          if (out_ch.base_address !== x.base_address) begin
            $error("base_address: expected %0d, got %0d", x.base_address,
                   out_ch.base_address);
            errors++;
          end
          if (out_ch.last !== x.last) begin
            $error("last: expected %0d, got %0d", x.last, out_ch.last);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                    logic [SIZE_W-1:0] size, logic [TIME_W-1:0] jt,
                                    logic [TIME_W-1:0] tk);
    job_cmd_t c;
    c.command  = cmd;
    c.job_id   = id;
    c.job_size = size;
    c.job_time = jt;
    c.ticks    = tk;
    pending_cmds.push_back(c);
  endfunction

  // Mostly a small id pool so adds, removes and clashes meet; sizes scaled to memory
  function automatic void queue_random_cmd();
    int              pick;
    longint unsigned mem;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] jt;
    logic [TIME_W-1:0] tk;
    pick = $urandom_range(0, 99);
    cmd = (pick < 45) ? CMD_ADD : (pick < 70) ? CMD_REMOVE :
          (pick < 96) ? CMD_ADVANCE : CMD_UNUSED;
    id = ($urandom_range(0, 99) < 6) ? ID_W'($urandom) : ID_W'($urandom_range(0, 23));
    mem = (mem_total > MEM_CAP) ? MEM_CAP : longint'(mem_total);
    pick = $urandom_range(0, 99);
    if (pick < 3)      size = '0;
    else if (pick < 6) size = SIZE_W'($urandom);
    else               size = SIZE_W'($urandom_range(1, int'(mem / 5) + 1));
    jt = ($urandom_range(0, 99) < 6) ? $urandom : TIME_W'($urandom_range(0, 30));
    pick = $urandom_range(0, 99);
    tk = (pick < 4) ? '1 : (pick < 9) ? $urandom : TIME_W'($urandom_range(0, 12));
    queue_cmd(cmd, id, size, jt, tk);
  endfunction

  // Hold until everything driven has been answered, then let the block settle
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_ch.valid || due_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_total(logic [TOT_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    mem_total = value;
    cfg_ch.valid <= 1'b0;
  endtask

  logic [TOT_W-1:0] totals [PHASES] = '{21'h100000, 21'd1, 21'h1FFFFF, 21'd300,
                                         21'd0, 21'd65536, 21'd4000, 21'd100000};

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_ADD;
    in_ch.job_id   = '0;
    in_ch.job_size = '0;
    in_ch.job_time = '0;
    in_ch.ticks    = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    rst_n          = 1'b0;
    mem_total      = TOTAL_RESET;
    for (int i = 0; i < JOBS; i++) job_valid[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size: whole memory, clashes, refusals, full table
    queue_cmd(CMD_ADD, 16'd0, 21'h100000, '0, '0);
    queue_cmd(CMD_ADD, 16'd0, 21'd1, 32'd5, '0);
    queue_cmd(CMD_ADD, 16'd1, 21'd1, 32'd5, '0);
    queue_cmd(CMD_ADVANCE, '0, '0, '0, 32'd0);
    queue_cmd(CMD_ADVANCE, '1, '1, '1, 32'd5);
    queue_cmd(CMD_ADD, 16'hFFFF, 21'd0, 32'd3, '0);
    queue_cmd(CMD_ADD, 16'd2, 21'h1FFFFF, 32'hFFFFFFFF, '0);
    queue_cmd(CMD_REMOVE, 16'd7, '0, '0, '0);
    for (int k = 0; k < JOBS; k++)
      queue_cmd(CMD_ADD, ID_W'(100 + k), SIZE_W'(4096 * (k % 3 + 1)),
                (k == JOBS - 1) ? 32'hFFFFFFFF : TIME_W'(k), '0);
    queue_cmd(CMD_ADD, 16'd50, 21'd1, 32'd1, '0);
    queue_cmd(CMD_REMOVE, 16'd103, '0, '0, '0);
    queue_cmd(CMD_ADD, 16'd51, 21'd10, 32'd2, '0);
    queue_cmd(CMD_UNUSED, 16'hFFFF, 21'h1FFFFF, '1, '1);
    queue_cmd(CMD_ADVANCE, '0, '0, '0, 32'hFFFFFFFF);
    wait_drained();

    // Random phases: each at its own memory size and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      write_total(totals[p]);
      case (p % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 84; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 84; end
        default: begin send_idle = 37; recv_idle = 37; end
      endcase
      for (int k = 0; k < PER_PHASE; k++) begin
        queue_random_cmd();
        if (k == PER_PHASE / 2 && p == 3) begin
          // hold the sender until every owed result is back
          while (pending_cmds.size() > 0 || in_ch.valid) @(posedge clk);
          hold_in = 1'b1;
          while (due_results.size() > 0) @(posedge clk);
          hold_in = 1'b0;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bfa_pkg.sv
sv/bfa_if.sv
sv/bfa_cell.sv
sv/best_fit_job_memory_allocator.sv
tb/sv/tb_top.sv
